### hdl/pmpd_pkg.sv
`timescale 1ns / 1ps

package pmpd_pkg;

  // status byte bit positions
  localparam int unsigned BIT_LEFT   = 0;
  localparam int unsigned BIT_RIGHT  = 1;
  localparam int unsigned BIT_SYNC   = 3;
  localparam int unsigned BIT_X_SIGN = 4;
  localparam int unsigned BIT_Y_SIGN = 5;
  localparam int unsigned BIT_X_OVF  = 6;
  localparam int unsigned BIT_Y_OVF  = 7;

  localparam int POS_MAX   = 32767;
  localparam int POS_MIN   = -32768;
  localparam int OVF_EXTRA = 255;

  typedef logic [1:0] edge_code_t;
  localparam edge_code_t EDGE_NONE    = 2'd0;
  localparam edge_code_t EDGE_PRESS   = 2'd1;
  localparam edge_code_t EDGE_RELEASE = 2'd2;

  typedef logic signed [15:0] pos_t;

  // one framed packet
  typedef struct packed {
    logic [7:0] status;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

  function automatic edge_code_t edge_of(input logic prev, input logic cur);
    edge_code_t e;
    if (prev == cur) e = EDGE_NONE;
    else if (cur)    e = EDGE_PRESS;
    else             e = EDGE_RELEASE;
    return e;
  endfunction

endpackage

### hdl/pmpd_byte_if.sv
`timescale 1ns / 1ps

interface pmpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/pmpd_result_if.sv
`timescale 1ns / 1ps

interface pmpd_result_if
  import pmpd_pkg::*;
;
  logic       valid;
  logic       ready;
  pos_t       pos_x;
  pos_t       pos_y;
  logic       left_level;
  logic       right_level;
  edge_code_t left_edge;
  edge_code_t right_edge;

  modport source (output valid, output pos_x, output pos_y, output left_level,
                  output right_level, output left_edge, output right_edge,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input left_level,
                input right_level, input left_edge, input right_edge,
                output ready);
endinterface

### hdl/pmpd_framer.sv
`timescale 1ns / 1ps

module pmpd_framer
  import pmpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  pmpd_byte_if.sink rx,
  output pkt_t      pkt,
  output logic      pkt_valid,
  input  logic      pkt_ready
);

  localparam logic [1:0] PH_STATUS = 2'd0;
  localparam logic [1:0] PH_X      = 2'd1;
  localparam logic [1:0] PH_Y      = 2'd2;

  logic [1:0] phase;
  logic [7:0] status_byte;
  logic [7:0] dx_byte;
  logic       take;

  // a waiting packet only blocks if the decoder cannot take it this cycle
  assign rx.ready = !pkt_valid || pkt_ready;
  assign take     = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STATUS;
      status_byte <= '0;
      dx_byte     <= '0;
      pkt_valid   <= 1'b0;
    end else begin
      if (pkt_valid && pkt_ready) pkt_valid <= 1'b0;
      if (take) begin
        unique case (phase)
          PH_X: begin
            dx_byte <= rx.rx_byte;
            phase   <= PH_Y;
          end
          PH_Y: begin
            pkt.status <= status_byte;
            pkt.dx     <= dx_byte;
            pkt.dy     <= rx.rx_byte;
            pkt_valid  <= 1'b1;
            phase      <= PH_STATUS;
          end
          default: begin
            // unused phase code behaves as the status phase
            if (rx.rx_byte[BIT_SYNC]) begin
              status_byte <= rx.rx_byte;
              phase       <= PH_X;
            end else begin
              phase <= PH_STATUS;
            end
          end
        endcase
      end
    end
  end

endmodule

### hdl/pmpd_decode.sv
`timescale 1ns / 1ps

module pmpd_decode
  import pmpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  pkt_t          pkt,
  input  logic          pkt_valid,
  output logic          pkt_ready,
  pmpd_result_if.source res
);

  pos_t acc_x;
  pos_t acc_y;
  logic left_held;
  logic right_held;

  logic signed [10:0] mv_x;
  logic signed [10:0] mv_y;
  logic signed [17:0] sum_x;
  logic signed [17:0] sum_y;
  pos_t acc_x_next;
  pos_t acc_y_next;
  logic take;

  // 9-bit two's complement movement, pushed a further 255 on overflow
  function automatic logic signed [10:0] movement(input logic [7:0] mag,
                                                  input logic neg,
                                                  input logic ovf);
    logic signed [10:0] d;
    d = $signed({{2{neg}}, neg, mag});
    if (ovf) begin
      if (neg) d = d - 11'sd255;
      else     d = d + 11'sd255;
    end
    return d;
  endfunction

  function automatic pos_t clamp(input logic signed [17:0] v);
    pos_t r;
    if (v > 18'sd32767)       r = pos_t'(POS_MAX);
    else if (v < -18'sd32768) r = pos_t'(POS_MIN);
    else                      r = v[15:0];
    return r;
  endfunction

  assign pkt_ready = !res.valid || res.ready;
  assign take      = pkt_valid && pkt_ready;

  always_comb begin
    mv_x  = movement(pkt.dx, pkt.status[BIT_X_SIGN], pkt.status[BIT_X_OVF]);
    mv_y  = movement(pkt.dy, pkt.status[BIT_Y_SIGN], pkt.status[BIT_Y_OVF]);
    sum_x = 18'(acc_x) + 18'(mv_x);
    // screen Y grows downward
    sum_y = 18'(acc_y) - 18'(mv_y);
    acc_x_next = clamp(sum_x);
    acc_y_next = clamp(sum_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x      <= '0;
      acc_y      <= '0;
      left_held  <= 1'b0;
      right_held <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      if (take) begin
        acc_x           <= acc_x_next;
        acc_y           <= acc_y_next;
        left_held       <= pkt.status[BIT_LEFT];
        right_held      <= pkt.status[BIT_RIGHT];
        res.valid       <= 1'b1;
        res.pos_x       <= acc_x_next;
        res.pos_y       <= acc_y_next;
        res.left_level  <= pkt.status[BIT_LEFT];
        res.right_level <= pkt.status[BIT_RIGHT];
        res.left_edge   <= edge_of(left_held, pkt.status[BIT_LEFT]);
        res.right_edge  <= edge_of(right_held, pkt.status[BIT_RIGHT]);
      end
    end
  end

endmodule

### hdl/ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// PS/2 mouse three-byte packet decoder.
// Throughput: one byte per cycle, set by the framer and decode stages, unless
// back-pressure from res.ready stalls them. The edge that takes the third byte loads
// the packet register, and the decode stage then loads the result register from it.
// Reset (synchronous, rst high): framing back to the status byte, position and
// button levels cleared, no result pending.

module ps2_mouse_packet_decoder
  import pmpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pmpd_byte_if.sink     rx,
  pmpd_result_if.source res
);

  pkt_t pkt;
  logic pkt_valid;
  logic pkt_ready;

  pmpd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready)
  );

  pmpd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .res       (res)
  );

endmodule
